FILE: design/letterbox_strip_alpha_blend_defines.svh
// ----------------------------------------------------------------------------
// Letterbox strip blender assertion macros
// Shared property templates for the port checker.
// ----------------------------------------------------------------------------
`ifndef LETTERBOX_STRIP_ALPHA_BLEND_DEFINES_SVH
`define LETTERBOX_STRIP_ALPHA_BLEND_DEFINES_SVH

// antecedent in one cycle implies consequent from the next, muted in reset
`define LSAB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// checked through reset: what reset leaves behind in the next cycle
`define LSAB_ASSERT_AFTER_RESET(lbl, clk, rst, cons, msg) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

FILE: design/lsab_pkg.sv
// ----------------------------------------------------------------------------
// Letterbox strip blender package
// Widths, register codes, payload and table types shared by the block.
// ----------------------------------------------------------------------------
package lsab_pkg;

   localparam int MAX_DIMENSION_DEF = 4096;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int FRAME_DIM_W = 13;
   localparam int FRACTION_W  = 17;
   localparam int COLOUR_W    = 32;

   localparam logic [FRAME_DIM_W-1:0] WIDTH_RESET    = 13'd640;
   localparam logic [FRAME_DIM_W-1:0] HEIGHT_RESET   = 13'd480;
   localparam logic [FRACTION_W-1:0]  FRACTION_RESET = 17'd32768;
   localparam logic [COLOUR_W-1:0]    COLOUR_RESET   = 32'hFF00_0000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH,
      CSR_FRAME_HEIGHT,
      CSR_STRIP_FRACTION,
      CSR_STRIP_COLOUR
   } csr_index_type;

   // pixel format
   localparam int PIXEL_W   = 32;
   localparam int CHANNEL_W = 8;
   localparam int CHANNELS  = 3;

   // weight tables
   localparam int WEIGHT_W    = 17;
   localparam int ALPHA_W     = 8;
   localparam int ENTRY_COUNT = 256;
   localparam int ENTRY_AW    = $clog2(ENTRY_COUNT);
   localparam int PRODUCT_W   = CHANNEL_W + WEIGHT_W;

   typedef struct packed {
      logic [WEIGHT_W-1:0] strip_weight;
      logic [WEIGHT_W-1:0] pixel_weight;
      logic [ALPHA_W-1:0]  alpha_out;
   } weight_entry_type;

   // table rebuild divider
   localparam int DIVIDEND_W = 32;
   localparam int DIVISOR_W  = 16;
   localparam int QUOT_W     = 17;

   // a/255 as (a * 32897) >> 23, exact for a up to 65025
   localparam int                   ALPHA_RECIP_W = 16;
   localparam logic [ALPHA_RECIP_W-1:0] ALPHA_RECIP = 16'd32897;
   localparam int                   ALPHA_SHIFT   = 23;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [1:0] {
      DIV_STRIP,
      DIV_PIXEL
   } div_sel_type;

   typedef enum logic [2:0] {
      ST_PREP,
      ST_LOAD,
      ST_DIV,
      ST_WRITE,
      ST_RUN
   } rebuild_state_type;

   // channel payloads
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_in;
      logic               frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_out;
      logic               frame_last;
   } rsp_payload_type;

endpackage

FILE: design/lsab_stream_if.sv
// ----------------------------------------------------------------------------
// Letterbox strip blender stream interface
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface lsab_stream_if #(
   parameter type payload_type = lsab_pkg::req_payload_type
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/letterbox_strip_alpha_blend.sv
// ----------------------------------------------------------------------------
// Letterbox strip blender
// Composites a strip colour over pixels on the top and bottom strip rows of
// each frame with the over operator, using per-alpha weight tables in RAM.
// ----------------------------------------------------------------------------
//
//   channel  dir  item                         handshake
//   -------  ---  ---------------------------  ------------------
//   req      in   pixel_in, frame_start        valid/ready
//   rsp      out  pixel_out, frame_last        valid/ready
//   csr      in   csr_index, csr_wdata         csr_wr_en, no wait
//
// One item per cycle unless rsp stalls or req.ready is held low; the stages are
// table RAM read, channel products, sum and clamp into the output register.
// Reset and every strip colour write rebuild the weight RAM: 256 entries
// (two 17-step divisions on the shared divider, alpha by a reciprocal
// multiply), with req.ready low throughout. Any csr write holds req.ready
// low while its write strobe shifts through settle_ff.
// A stalled rsp backs up through the three stages before req.ready drops.
// ----------------------------------------------------------------------------
module letterbox_strip_alpha_blend #(
   parameter int MAX_DIMENSION = lsab_pkg::MAX_DIMENSION_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   lsab_stream_if.sink                      req,
   lsab_stream_if.source                    rsp,
   input  logic                             csr_wr_en,
   input  logic [lsab_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lsab_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CNT_W = $clog2(MAX_DIMENSION);
   localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
   localparam int CW    = lsab_pkg::CHANNEL_W;
   localparam int PW    = lsab_pkg::PRODUCT_W;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [lsab_pkg::FRAME_DIM_W-1:0] cfg_width_ff;
   logic [lsab_pkg::FRAME_DIM_W-1:0] cfg_height_ff;
   logic [lsab_pkg::FRACTION_W-1:0]  cfg_fraction_ff;
   logic [lsab_pkg::COLOUR_W-1:0]    cfg_colour_ff;
   logic                             colour_write;
   logic [1:0]                       settle_ff;

   assign colour_write = csr_wr_en && (csr_index == lsab_pkg::CSR_STRIP_COLOUR);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff    <= lsab_pkg::WIDTH_RESET;
         cfg_height_ff   <= lsab_pkg::HEIGHT_RESET;
         cfg_fraction_ff <= lsab_pkg::FRACTION_RESET;
         cfg_colour_ff   <= lsab_pkg::COLOUR_RESET;
      end else if (csr_wr_en) begin
         case (lsab_pkg::csr_index_type'(csr_index))
            lsab_pkg::CSR_FRAME_WIDTH: begin
               cfg_width_ff <= csr_wdata[lsab_pkg::FRAME_DIM_W-1:0];
            end
            lsab_pkg::CSR_FRAME_HEIGHT: begin
               cfg_height_ff <= csr_wdata[lsab_pkg::FRAME_DIM_W-1:0];
            end
            lsab_pkg::CSR_STRIP_FRACTION: begin
               cfg_fraction_ff <= csr_wdata[lsab_pkg::FRACTION_W-1:0];
            end
            lsab_pkg::CSR_STRIP_COLOUR: begin
               cfg_colour_ff <= csr_wdata[lsab_pkg::COLOUR_W-1:0];
            end
            default: ;
         endcase
      end
   end

   // derived limits settle through w_ff/h_ff and then the limit registers after a write
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= '0;
      end else begin
         settle_ff <= {settle_ff[0], csr_wr_en};
      end
   end

   // ------------------------------------------------------------------
   // derived frame limits: clamped size, then center and strip height
   // ------------------------------------------------------------------
   logic [DIM_W-1:0] w_ff, w_in;
   logic [DIM_W-1:0] h_ff, h_in;
   logic [CNT_W-1:0] wm1_ff, hm1_ff, cy_ff;
   logic [DIM_W-1:0] strip_ff;
   logic [CNT_W+lsab_pkg::FRACTION_W-1:0] strip_prod;

   always_comb begin
      if (cfg_width_ff == '0) begin
         w_in = DIM_W'(1);
      end else if (32'(cfg_width_ff) > 32'(MAX_DIMENSION)) begin
         w_in = DIM_W'(MAX_DIMENSION);
      end else begin
         w_in = DIM_W'(cfg_width_ff);
      end
      if (cfg_height_ff == '0) begin
         h_in = DIM_W'(1);
      end else if (32'(cfg_height_ff) > 32'(MAX_DIMENSION)) begin
         h_in = DIM_W'(MAX_DIMENSION);
      end else begin
         h_in = DIM_W'(cfg_height_ff);
      end
      strip_prod = (CNT_W+lsab_pkg::FRACTION_W)'(h_ff >> 1)
                 * (CNT_W+lsab_pkg::FRACTION_W)'(cfg_fraction_ff);
   end

   always_ff @(posedge clock) begin
      w_ff     <= w_in;
      h_ff     <= h_in;
      wm1_ff   <= CNT_W'(w_ff - DIM_W'(1));
      hm1_ff   <= CNT_W'(h_ff - DIM_W'(1));
      cy_ff    <= CNT_W'(h_ff >> 1);
      strip_ff <= DIM_W'(strip_prod >> 16);
   end

   // ------------------------------------------------------------------
   // table rebuild sequencer
   // ------------------------------------------------------------------
   lsab_pkg::rebuild_state_type state_ff, state_in;
   lsab_pkg::div_sel_type       sel_ff, sel_in;
   lsab_pkg::div_req_type       div_req;
   lsab_pkg::div_rsp_type       div_rsp;
   logic [lsab_pkg::ENTRY_AW-1:0] idx_ff, idx_in;
   logic [15:0]                 prod_ff;
   logic [15:0]                 a_ff;
   logic [15:0]                 sai_ff;
   logic [lsab_pkg::WEIGHT_W-1:0] sw_ff, pw_ff;
   logic [7:0]                  ai;
   logic [15:0]                 prod_in;
   logic [15:0]                 sai_in;
   logic [31:0]                 alpha_prod;
   logic                        mem_we;
   logic                        q_latch;
   lsab_pkg::weight_entry_type  wr_entry;

   assign ai      = cfg_colour_ff[31:24];
   assign prod_in = 16'(idx_ff) * 16'(8'd255 - ai);
   assign sai_in  = {ai, 8'h00} - {8'h00, ai};

   always_comb begin
      state_in         = state_ff;
      idx_in           = idx_ff;
      sel_in           = sel_ff;
      mem_we           = 1'b0;
      q_latch          = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = {sai_ff, 16'h0000};
      div_req.divisor  = a_ff;
      case (sel_ff)
         lsab_pkg::DIV_STRIP: begin
            div_req.dividend = {sai_ff, 16'h0000};
         end
         lsab_pkg::DIV_PIXEL: begin
            div_req.dividend = {prod_ff, 16'h0000};
         end
         default: ;
      endcase
      case (state_ff)
         lsab_pkg::ST_PREP: begin
            sel_in   = lsab_pkg::DIV_STRIP;
            state_in = lsab_pkg::ST_LOAD;
         end
         lsab_pkg::ST_LOAD: begin
            div_req.start = 1'b1;
            state_in      = lsab_pkg::ST_DIV;
         end
         lsab_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               q_latch = 1'b1;
               if (sel_ff == lsab_pkg::DIV_PIXEL) begin
                  state_in = lsab_pkg::ST_WRITE;
               end else begin
                  sel_in   = lsab_pkg::DIV_PIXEL;
                  state_in = lsab_pkg::ST_LOAD;
               end
            end
         end
         lsab_pkg::ST_WRITE: begin
            mem_we   = 1'b1;
            idx_in   = idx_ff + lsab_pkg::ENTRY_AW'(1);
            state_in = (idx_ff == lsab_pkg::ENTRY_AW'(lsab_pkg::ENTRY_COUNT - 1))
                     ? lsab_pkg::ST_RUN : lsab_pkg::ST_PREP;
         end
         lsab_pkg::ST_RUN: ;
         default: begin
            state_in = lsab_pkg::ST_PREP;
         end
      endcase
      // a new colour restarts the sweep from the first entry
      if (colour_write) begin
         state_in = lsab_pkg::ST_PREP;
         idx_in   = '0;
         sel_in   = lsab_pkg::DIV_STRIP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsab_pkg::ST_PREP;
         idx_ff   <= '0;
         sel_ff   <= lsab_pkg::DIV_STRIP;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         sel_ff   <= sel_in;
      end
   end

   // a = 255*ai + ao*(255-ai); quotients land by divider select
   always_ff @(posedge clock) begin
      if (state_ff == lsab_pkg::ST_PREP) begin
         prod_ff <= prod_in;
         sai_ff  <= sai_in;
         a_ff    <= sai_in + prod_in;
      end
      if (q_latch) begin
         case (sel_ff)
            lsab_pkg::DIV_STRIP: sw_ff <= div_rsp.quotient;
            lsab_pkg::DIV_PIXEL: pw_ff <= div_rsp.quotient;
            default: ;
         endcase
      end
   end

   // output alpha a/255 by reciprocal multiply
   assign alpha_prod = 32'(a_ff) * 32'(lsab_pkg::ALPHA_RECIP);

   // fully transparent pair gives all-zero entry
   always_comb begin
      if (a_ff == '0) begin
         wr_entry = '0;
      end else begin
         wr_entry.strip_weight = sw_ff;
         wr_entry.pixel_weight = pw_ff;
         wr_entry.alpha_out    = alpha_prod[lsab_pkg::ALPHA_SHIFT +: lsab_pkg::ALPHA_W];
      end
   end

   lsab_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ------------------------------------------------------------------
   // pixel pipeline handshake
   // ------------------------------------------------------------------
   logic s1_v_ff, s2_v_ff, out_v_ff;
   logic s1_en, s2_en, out_en;
   logic accept;

   assign out_en    = !out_v_ff || rsp.ready;
   assign s2_en     = !s2_v_ff || out_en;
   assign s1_en     = !s1_v_ff || s2_en;
   assign req.ready = (state_ff == lsab_pkg::ST_RUN) && (settle_ff == '0) && s1_en;
   assign accept    = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_v_ff <= accept;
         end
         if (s2_en) begin
            s2_v_ff <= s1_v_ff;
         end
         if (out_en) begin
            out_v_ff <= s2_v_ff;
         end
      end
   end

   // ------------------------------------------------------------------
   // raster position
   // ------------------------------------------------------------------
   logic [CNT_W-1:0] col_ff, row_ff;
   logic [CNT_W-1:0] col_cur, row_cur;
   logic [CNT_W-1:0] col_in, row_in;
   logic [CNT_W:0]   col_nx, row_nx;
   logic             last_cur;

   always_comb begin
      col_cur  = req.payload.frame_start ? '0 : col_ff;
      row_cur  = req.payload.frame_start ? '0 : row_ff;
      last_cur = (col_cur == wm1_ff) && (row_cur == hm1_ff);
      col_nx   = {1'b0, col_cur} + (CNT_W+1)'(1);
      row_nx   = {1'b0, row_cur} + (CNT_W+1)'(1);
      col_in   = col_nx[CNT_W-1:0];
      row_in   = row_cur;
      if (32'(col_nx) >= 32'(w_ff)) begin
         col_in = '0;
         row_in = (32'(row_nx) >= 32'(h_ff)) ? '0 : row_nx[CNT_W-1:0];
      end
      // position left outside a shrunk frame falls back to row 0
      if (32'(row_in) >= 32'(h_ff)) begin
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------
   // weight RAM: sweep writes, one registered read per accepted item
   // ------------------------------------------------------------------
   lsab_pkg::weight_entry_type table_mem [lsab_pkg::ENTRY_COUNT];
   lsab_pkg::weight_entry_type ent_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[idx_ff] <= wr_entry;
      end
      if (accept) begin
         ent_ff <= table_mem[req.payload.pixel_in[31:24]];
      end
   end

   // ------------------------------------------------------------------
   // stage 1: item registers, strip row test
   // ------------------------------------------------------------------
   logic [lsab_pkg::PIXEL_W-1:0] s1_pix_ff;
   logic [CNT_W-1:0]             s1_row_ff;
   logic                         s1_last_ff;
   logic [CNT_W-1:0]             row_offset;
   logic                         strip_row;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= req.payload.pixel_in;
         s1_row_ff  <= row_cur;
         s1_last_ff <= last_cur;
      end
   end

   // strip row when cy - |y - cy| <= strip (negative side always qualifies)
   always_comb begin
      row_offset = (s1_row_ff >= cy_ff) ? (s1_row_ff - cy_ff) : (cy_ff - s1_row_ff);
      strip_row  = (row_offset > cy_ff) || (32'(cy_ff - row_offset) <= 32'(strip_ff));
   end

   // ------------------------------------------------------------------
   // stage 2: channel products
   // ------------------------------------------------------------------
   logic [PW-1:0]                s2_ps_ff [lsab_pkg::CHANNELS];
   logic [PW-1:0]                s2_pp_ff [lsab_pkg::CHANNELS];
   logic [lsab_pkg::ALPHA_W-1:0] s2_alpha_ff;
   logic [lsab_pkg::PIXEL_W-1:0] s2_pix_ff;
   logic                         s2_strip_ff;
   logic                         s2_last_ff;

   always_ff @(posedge clock) begin
      if (s2_en && s1_v_ff) begin
         for (int c = 0; c < lsab_pkg::CHANNELS; c++) begin
            s2_ps_ff[c] <= PW'(cfg_colour_ff[c*CW +: CW]) * PW'(ent_ff.strip_weight);
            s2_pp_ff[c] <= PW'(s1_pix_ff[c*CW +: CW]) * PW'(ent_ff.pixel_weight);
         end
         s2_alpha_ff <= ent_ff.alpha_out;
         s2_pix_ff   <= s1_pix_ff;
         s2_strip_ff <= strip_row;
         s2_last_ff  <= s1_last_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: sum, scale, clamp into the output register
   // ------------------------------------------------------------------
   logic [PW:0]                  sum_w   [lsab_pkg::CHANNELS];
   logic [CW-1:0]                blend_w [lsab_pkg::CHANNELS];
   lsab_pkg::rsp_payload_type    out_payload_in, out_payload_ff;

   always_comb begin
      for (int c = 0; c < lsab_pkg::CHANNELS; c++) begin
         sum_w[c]   = {1'b0, s2_ps_ff[c]} + {1'b0, s2_pp_ff[c]};
         blend_w[c] = (sum_w[c][PW:16] > (PW-15)'(255)) ? {CW{1'b1}}
                                                        : sum_w[c][16 +: CW];
      end
      if (s2_strip_ff) begin
         out_payload_in.pixel_out = {s2_alpha_ff, blend_w[2], blend_w[1], blend_w[0]};
      end else begin
         out_payload_in.pixel_out = s2_pix_ff;
      end
      out_payload_in.frame_last = s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (out_en && s2_v_ff) begin
         out_payload_ff <= out_payload_in;
      end
   end

   assign rsp.valid   = out_v_ff;
   assign rsp.payload = out_payload_ff;

endmodule

FILE: design/lsab_divider.sv
// ----------------------------------------------------------------------------
// Letterbox strip blender divider
// Restoring divider, one quotient bit per cycle, for the table rebuild.
// ----------------------------------------------------------------------------
module lsab_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  lsab_pkg::div_req_type div_req,
   output lsab_pkg::div_rsp_type div_rsp
);

   localparam int STEP_W = $clog2(lsab_pkg::QUOT_W + 1);

   logic [lsab_pkg::DIVISOR_W-1:0] rem_ff;
   logic [lsab_pkg::DIVISOR_W-1:0] rem_in;
   logic [lsab_pkg::DIVISOR_W-1:0] divisor_ff;
   logic [lsab_pkg::QUOT_W-1:0]    q_ff;
   logic [STEP_W-1:0]              cnt_ff;
   logic                           done_ff;
   logic [lsab_pkg::DIVISOR_W:0]   trial;
   logic [lsab_pkg::DIVISOR_W:0]   diff;
   logic                           ge;
   logic                           busy;

   assign busy = (cnt_ff != '0);

   // one restoring step: shift in the next dividend bit, try to subtract
   always_comb begin
      trial  = {rem_ff, q_ff[lsab_pkg::QUOT_W-1]};
      diff   = trial - {1'b0, divisor_ff};
      ge     = (trial >= {1'b0, divisor_ff});
      rem_in = ge ? diff[lsab_pkg::DIVISOR_W-1:0] : trial[lsab_pkg::DIVISOR_W-1:0];
   end

   // step counter and done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (div_req.start) begin
         cnt_ff  <= STEP_W'(lsab_pkg::QUOT_W);
         done_ff <= 1'b0;
      end else if (busy) begin
         cnt_ff  <= cnt_ff - STEP_W'(1);
         done_ff <= (cnt_ff == STEP_W'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   // quotient below 2^QUOT_W, so the high dividend bits start below the divisor
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff     <= lsab_pkg::DIVISOR_W'(div_req.dividend >> lsab_pkg::QUOT_W);
         q_ff       <= div_req.dividend[lsab_pkg::QUOT_W-1:0];
         divisor_ff <= div_req.divisor;
      end else if (busy) begin
         rem_ff <= rem_in;
         q_ff   <= {q_ff[lsab_pkg::QUOT_W-2:0], ge};
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = q_ff;

endmodule

FILE: design/lsab_checker.sv
// ----------------------------------------------------------------------------
// Letterbox strip blender port checker
// Port-level properties of the blender, bound to the top level.
// ----------------------------------------------------------------------------
`include "letterbox_strip_alpha_blend_defines.svh"

module lsab_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [lsab_pkg::PIXEL_W-1:0]     rsp_pixel_out,
   input logic                             rsp_frame_last,
   input logic                             csr_wr_en,
   input logic [lsab_pkg::CSR_INDEX_W-1:0] csr_index
);

   // a stalled result item holds
   `LSAB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_frame_last), "rsp item changed while stalled")

   // reset starts the table sweep, so no item is taken right after it
   `LSAB_ASSERT_AFTER_RESET(a_reset_sweep, clock, reset, !req_ready, "req ready right after reset")

   // derived limits are still settling after any register write
   `LSAB_ASSERT_NEXT(a_csr_settle, clock, reset, csr_wr_en, !req_ready, "req ready right after csr write")

   // a colour write rebuilds the tables and keeps input closed
   `LSAB_ASSERT_NEXT(a_colour_sweep, clock, reset, csr_wr_en && (csr_index == lsab_pkg::CSR_STRIP_COLOUR), ##2 !req_ready, "req ready during table rebuild")

endmodule

bind letterbox_strip_alpha_blend lsab_checker u_lsab_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_pixel_out  (rsp.payload.pixel_out),
   .rsp_frame_last (rsp.payload.frame_last),
   .csr_wr_en      (csr_wr_en),
   .csr_index      (csr_index)
);
